// ===== rtl/core/qpmm_pkg.sv =====
// types, constants and helper functions of the quad pid motor mixer
package qpmm_pkg;

    // fixed point format of all quantities
    localparam int FRACTION_BITS = 8;
    localparam int ONE           = 1 << FRACTION_BITS;

    // field widths
    localparam int ALT_W     = 18;
    localparam int ANG_W     = 17;
    localparam int YAW_W     = 17;
    localparam int STICK_W   = 11;
    localparam int MOTOR_W   = 16;
    localparam int LIMIT_W   = 16;
    localparam int STATE_W   = 32;

    // input tdata layout, lowest field first
    localparam int ALT_LSB    = 0;
    localparam int PITCH_LSB  = ALT_LSB + ALT_W;
    localparam int ROLL_LSB   = PITCH_LSB + ANG_W;
    localparam int YAWM_LSB   = ROLL_LSB + ANG_W;
    localparam int STK_Y_LSB  = YAWM_LSB + YAW_W;
    localparam int STK_T_LSB  = STK_Y_LSB + STICK_W;
    localparam int STK_R_LSB  = STK_T_LSB + STICK_W;
    localparam int STK_P_LSB  = STK_R_LSB + STICK_W;
    localparam int IN_BITS    = STK_P_LSB + STICK_W;
    localparam int S_TDATA_W  = ((IN_BITS + 7) / 8) * 8;
    localparam int S_TUSER_W  = 1;
    localparam int M_TDATA_W  = 4 * MOTOR_W;

    // configuration port
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 17;
    localparam logic [CFG_IDX_W-1:0] CFG_YAW_REF   = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] CFG_INT_LIMIT = CFG_IDX_W'(1);
    localparam logic [LIMIT_W-1:0]   LIMIT_RESET   = LIMIT_W'(6400);

    // axis index, also the loop counter
    localparam logic [1:0] IDX_ALT   = 2'd0;
    localparam logic [1:0] IDX_PITCH = 2'd1;
    localparam logic [1:0] IDX_ROLL  = 2'd2;
    localparam logic [1:0] IDX_YAW   = 2'd3;
    localparam logic [1:0] IDX_LAST  = IDX_YAW;

    // stick mapping
    localparam int STICK_CENTER = 625;
    localparam int THR_SCALE    = 4;
    localparam int YAW_SCALE    = 12;
    localparam int DIV_THR      = 5;
    localparam int DIV_ANG      = 25;
    localparam int DIV_YAW      = 125;
    localparam int DIV_SMO      = 5;
    localparam int YAW_OFFSET   = 180 * ONE;

    // signed numerators are lifted by a multiple of the divisor so that the
    // reciprocal multiply only sees values in 0 .. 2^(X_W-1)
    localparam int X_W      = 24;
    localparam int Q_ANG    = 1 << 14;
    localparam int Q_YAW    = 1 << 14;
    localparam int Q_SMO    = 1 << 17;
    localparam int BIAS_ANG = DIV_ANG * Q_ANG;
    localparam int BIAS_YAW = DIV_YAW * Q_YAW;
    localparam int BIAS_SMO = DIV_SMO * Q_SMO;

    localparam int TGT_OFS_THR   = DIV_THR / 2;
    localparam int TGT_OFS_PITCH = STICK_CENTER * ONE + DIV_ANG / 2 + BIAS_ANG;
    localparam int TGT_OFS_ROLL  = DIV_ANG / 2 + BIAS_ANG - STICK_CENTER * ONE;
    localparam int TGT_OFS_YAW   = DIV_YAW / 2 + BIAS_YAW - STICK_CENTER * YAW_SCALE * ONE;
    localparam int SMO_OFS       = DIV_SMO / 2 + BIAS_SMO;

    // ceil(2^32 / d): exact floor quotient for numerators below 2^(X_W-1)
    localparam int     RECIP_SHIFT = 32;
    localparam longint RECIP_THR = ((longint'(1) << RECIP_SHIFT) + DIV_THR - 1) / DIV_THR;
    localparam longint RECIP_ANG = ((longint'(1) << RECIP_SHIFT) + DIV_ANG - 1) / DIV_ANG;
    localparam longint RECIP_YAW = ((longint'(1) << RECIP_SHIFT) + DIV_YAW - 1) / DIV_YAW;
    localparam longint RECIP_SMO = ((longint'(1) << RECIP_SHIFT) + DIV_SMO - 1) / DIV_SMO;

    // shared multiplier and gain scaling
    localparam int MUL_A_W    = 33;
    localparam int MUL_B_W    = 32;
    localparam int PROD_W     = 64;
    localparam int GAIN_FRAC  = 24;
    localparam int ROUND_HALF = 1 << (GAIN_FRAC - 1);
    localparam int U_W        = 28;
    localparam int MIX_W      = 30;

    typedef enum logic [3:0] {
        S_IDLE,
        S_TGT,
        S_TGT_Q,
        S_SMO,
        S_SMO_Q,
        S_ERR,
        S_PI,
        S_II,
        S_DD,
        S_U,
        S_MIX
    } state_t;

    function automatic logic signed [MUL_B_W-1:0] gain_p(input logic [1:0] idx);
        logic signed [MUL_B_W-1:0] g;
        case (idx)
            IDX_ALT:   g = MUL_B_W'(16777216);
            IDX_PITCH: g = MUL_B_W'(50331648);
            IDX_ROLL:  g = MUL_B_W'(50331648);
            IDX_YAW:   g = MUL_B_W'(8388608);
            default:   g = '0;
        endcase
        return g;
    endfunction

    function automatic logic signed [MUL_B_W-1:0] gain_i(input logic [1:0] idx);
        logic signed [MUL_B_W-1:0] g;
        case (idx)
            IDX_ALT:   g = MUL_B_W'(167772);
            IDX_PITCH: g = MUL_B_W'(167772);
            IDX_ROLL:  g = MUL_B_W'(167772);
            IDX_YAW:   g = MUL_B_W'(1678);
            default:   g = '0;
        endcase
        return g;
    endfunction

    function automatic logic signed [MUL_B_W-1:0] gain_d(input logic [1:0] idx);
        logic signed [MUL_B_W-1:0] g;
        case (idx)
            IDX_ALT:   g = MUL_B_W'(16777);
            IDX_PITCH: g = MUL_B_W'(16777);
            IDX_ROLL:  g = MUL_B_W'(16777);
            IDX_YAW:   g = MUL_B_W'(17);
            default:   g = '0;
        endcase
        return g;
    endfunction

    function automatic logic signed [STATE_W-1:0] sat32(input logic signed [STATE_W+2:0] v);
        logic signed [STATE_W-1:0] r;
        if ((v[STATE_W+2:STATE_W-1] == '0) || (v[STATE_W+2:STATE_W-1] == '1))
            r = v[STATE_W-1:0];
        else if (v[STATE_W+2])
            r = {1'b1, {(STATE_W-1){1'b0}}};
        else
            r = {1'b0, {(STATE_W-1){1'b1}}};
        return r;
    endfunction

    function automatic logic [MOTOR_W-1:0] motor_clamp(input logic signed [MIX_W-1:0] v);
        logic [MOTOR_W-1:0] r;
        if (v[MIX_W-1])
            r = '0;
        else if (|v[MIX_W-2:MOTOR_W])
            r = '1;
        else
            r = v[MOTOR_W-1:0];
        return r;
    endfunction

endpackage

// ===== rtl/core/quad_pid_motor_mixer_top.sv =====
// x-frame quad pid controller and motor mixer around one shared multiplier
// each axis runs its steps in order through the shared multiplier (target,
// smoothing, error, three gain products, rounding), then the mix forms the result;
// a new request is taken only once the previous result has been mixed
// the output register lets the next request start while a result waits
// reset: async active low, clears commands, integrals, previous errors and sets
// yaw_reference to 0 and integral_limit to 6400
module quad_pid_motor_mixer_top (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              s_axis_tvalid,
    output logic                              s_axis_tready,
    // altitude_meas, pitch_meas, roll_meas, yaw_meas, yaw_stick, throttle_stick,
    // roll_stick, pitch_stick
    input  logic [qpmm_pkg::S_TDATA_W-1:0]    s_axis_tdata,
    // sticks_valid
    input  logic [qpmm_pkg::S_TUSER_W-1:0]    s_axis_tuser,
    output logic                              m_axis_tvalid,
    input  logic                              m_axis_tready,
    // motor_front_a, motor_front_b, motor_rear_a, motor_rear_b
    output logic [qpmm_pkg::M_TDATA_W-1:0]    m_axis_tdata,
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [qpmm_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [qpmm_pkg::CFG_DATA_W-1:0]   cfg_data
);
    import qpmm_pkg::*;

    state_t state_reg, state_next;
    logic [1:0] idx_reg, idx_next;

    logic [ALT_W-1:0]          alt_reg, alt_next;
    logic signed [ANG_W-1:0]   pitch_reg, pitch_next;
    logic signed [ANG_W-1:0]   roll_reg, roll_next;
    logic [YAW_W-1:0]          yawm_reg, yawm_next;
    logic [STICK_W-1:0]        stk_yaw_reg, stk_yaw_next;
    logic [STICK_W-1:0]        stk_thr_reg, stk_thr_next;
    logic [STICK_W-1:0]        stk_roll_reg, stk_roll_next;
    logic [STICK_W-1:0]        stk_pitch_reg, stk_pitch_next;

    logic signed [CFG_DATA_W-1:0] yaw_ref_reg, yaw_ref_next;
    logic [LIMIT_W-1:0]           limit_reg, limit_next;

    logic signed [STATE_W-1:0] cmd_reg [4];
    logic signed [STATE_W-1:0] cmd_next [4];
    logic signed [STATE_W-1:0] integ_reg [4];
    logic signed [STATE_W-1:0] integ_next [4];
    logic signed [STATE_W-1:0] prev_reg [4];
    logic signed [STATE_W-1:0] prev_next [4];
    logic signed [U_W-1:0]     u_reg [4];
    logic signed [U_W-1:0]     u_next [4];

    logic signed [X_W-1:0]     t_reg, t_next;
    logic signed [STATE_W-1:0] e_reg, e_next;
    logic signed [PROD_W-1:0]  prod_reg, prod_next;
    logic signed [PROD_W-1:0]  sum_reg, sum_next;

    logic                      out_valid_reg, out_valid_next;
    logic [M_TDATA_W-1:0]      out_data_reg, out_data_next;

    // datapath around the shared multiplier
    logic signed [MUL_A_W-1:0]         mul_a;
    logic signed [MUL_B_W-1:0]         mul_b;
    logic signed [MUL_A_W+MUL_B_W-1:0] mul_p;

    logic signed [STATE_W-1:0]   tgt_w;
    logic signed [MUL_B_W-1:0]   tgt_recip;
    logic signed [X_W-1:0]       tgt_qofs;
    logic signed [STATE_W-1:0]   cmd_cur;
    logic signed [STATE_W+1:0]   smo_w;
    logic signed [STATE_W+2:0]   err_w;
    logic signed [STATE_W+1:0]   acc_w;
    logic signed [STATE_W+1:0]   lim_w;
    logic signed [STATE_W+1:0]   acc_clamped;
    logic signed [PROD_W-1:0]    u_tot;
    logic signed [MIX_W-1:0]     u_alt, u_pitch, u_roll, u_yaw;
    logic signed [MIX_W-1:0]     mix_tp, mix_tpp, mix_yr, mix_ym;
    logic                        in_req;

    assign mul_p = mul_a * mul_b;
    assign in_req = s_axis_tvalid && s_axis_tready;

    assign s_axis_tready = (state_reg == S_IDLE);
    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;
    assign cfg_ready     = 1'b1;

    assign cmd_cur = cmd_reg[idx_reg];

    // stick numerator, already lifted to a non-negative value
    always_comb
    begin
        case (idx_reg)
            IDX_ALT:
            begin
                tgt_w     = STATE_W'(32'(stk_thr_reg) * (THR_SCALE * ONE) + TGT_OFS_THR);
                tgt_recip = MUL_B_W'(RECIP_THR);
                tgt_qofs  = X_W'(0);
            end
            IDX_PITCH:
            begin
                tgt_w     = STATE_W'(TGT_OFS_PITCH - 32'(stk_pitch_reg) * ONE);
                tgt_recip = MUL_B_W'(RECIP_ANG);
                tgt_qofs  = X_W'(Q_ANG);
            end
            IDX_ROLL:
            begin
                tgt_w     = STATE_W'(32'(stk_roll_reg) * ONE + TGT_OFS_ROLL);
                tgt_recip = MUL_B_W'(RECIP_ANG);
                tgt_qofs  = X_W'(Q_ANG);
            end
            default:
            begin
                tgt_w     = STATE_W'(32'(stk_yaw_reg) * (YAW_SCALE * ONE) + TGT_OFS_YAW);
                tgt_recip = MUL_B_W'(RECIP_YAW);
                tgt_qofs  = X_W'(Q_YAW);
            end
        endcase
    end

    // 3*cmd + 2*target, rounded and lifted for the divide by five
    assign smo_w = {{2{cmd_cur[STATE_W-1]}}, cmd_cur}
                 + ({{2{cmd_cur[STATE_W-1]}}, cmd_cur} <<< 1)
                 + ({{(STATE_W+2-X_W){t_reg[X_W-1]}}, t_reg} <<< 1)
                 + (STATE_W+2)'(SMO_OFS);

    always_comb
    begin
        case (idx_reg)
            IDX_ALT:
                err_w = {{3{cmd_cur[STATE_W-1]}}, cmd_cur}
                      - {{(STATE_W+3-ALT_W){1'b0}}, alt_reg};
            IDX_PITCH:
                err_w = {{3{cmd_cur[STATE_W-1]}}, cmd_cur}
                      - {{(STATE_W+3-ANG_W){pitch_reg[ANG_W-1]}}, pitch_reg};
            IDX_ROLL:
                err_w = {{3{cmd_cur[STATE_W-1]}}, cmd_cur}
                      - {{(STATE_W+3-ANG_W){roll_reg[ANG_W-1]}}, roll_reg};
            default:
                err_w = {{(STATE_W+3-CFG_DATA_W){yaw_ref_reg[CFG_DATA_W-1]}}, yaw_ref_reg}
                      - {{3{cmd_cur[STATE_W-1]}}, cmd_cur}
                      - {{(STATE_W+3-YAW_W){1'b0}}, yawm_reg}
                      + (STATE_W+3)'(YAW_OFFSET);
        endcase
    end

    // integral step with symmetric clamp
    assign acc_w = {{2{integ_reg[idx_reg][STATE_W-1]}}, integ_reg[idx_reg]}
                 + {{2{e_reg[STATE_W-1]}}, e_reg};
    assign lim_w = {{(STATE_W+2-LIMIT_W){1'b0}}, limit_reg};

    always_comb
    begin
        if (acc_w > lim_w)
            acc_clamped = lim_w;
        else if (acc_w < -lim_w)
            acc_clamped = -lim_w;
        else
            acc_clamped = acc_w;
    end

    assign u_tot = sum_reg + prod_reg + PROD_W'(ROUND_HALF);

    // x-frame mix from two levels of adders
    assign u_alt   = {{(MIX_W-U_W){u_reg[IDX_ALT][U_W-1]}}, u_reg[IDX_ALT]};
    assign u_pitch = {{(MIX_W-U_W){u_reg[IDX_PITCH][U_W-1]}}, u_reg[IDX_PITCH]};
    assign u_roll  = {{(MIX_W-U_W){u_reg[IDX_ROLL][U_W-1]}}, u_reg[IDX_ROLL]};
    assign u_yaw   = {{(MIX_W-U_W){u_reg[IDX_YAW][U_W-1]}}, u_reg[IDX_YAW]};
    assign mix_tp  = u_alt - u_pitch;
    assign mix_tpp = u_alt + u_pitch;
    assign mix_yr  = u_yaw + u_roll;
    assign mix_ym  = u_yaw - u_roll;

    always_comb
    begin
        state_next     = state_reg;
        idx_next       = idx_reg;
        alt_next       = alt_reg;
        pitch_next     = pitch_reg;
        roll_next      = roll_reg;
        yawm_next      = yawm_reg;
        stk_yaw_next   = stk_yaw_reg;
        stk_thr_next   = stk_thr_reg;
        stk_roll_next  = stk_roll_reg;
        stk_pitch_next = stk_pitch_reg;
        yaw_ref_next   = yaw_ref_reg;
        limit_next     = limit_reg;
        cmd_next       = cmd_reg;
        integ_next     = integ_reg;
        prev_next      = prev_reg;
        u_next         = u_reg;
        t_next         = t_reg;
        e_next         = e_reg;
        prod_next      = prod_reg;
        sum_next       = sum_reg;
        out_valid_next = out_valid_reg;
        out_data_next  = out_data_reg;
        mul_a          = '0;
        mul_b          = '0;

        if (out_valid_reg && m_axis_tready)
            out_valid_next = 1'b0;

        if (cfg_valid)
        begin
            case (cfg_index)
                CFG_YAW_REF:   yaw_ref_next = cfg_data;
                CFG_INT_LIMIT: limit_next = cfg_data[LIMIT_W-1:0];
                default:       ;
            endcase
        end

        case (state_reg)
            S_IDLE:
            begin
                if (in_req)
                begin
                    alt_next   = s_axis_tdata[ALT_LSB +: ALT_W];
                    pitch_next = s_axis_tdata[PITCH_LSB +: ANG_W];
                    roll_next  = s_axis_tdata[ROLL_LSB +: ANG_W];
                    yawm_next  = s_axis_tdata[YAWM_LSB +: YAW_W];
                    if (s_axis_tuser[0])
                    begin
                        stk_yaw_next   = s_axis_tdata[STK_Y_LSB +: STICK_W];
                        stk_thr_next   = s_axis_tdata[STK_T_LSB +: STICK_W];
                        stk_roll_next  = s_axis_tdata[STK_R_LSB +: STICK_W];
                        stk_pitch_next = s_axis_tdata[STK_P_LSB +: STICK_W];
                    end
                    else
                    begin
                        // no radio link: centered sticks, throttle at ground
                        stk_yaw_next   = STICK_W'(STICK_CENTER);
                        stk_thr_next   = '0;
                        stk_roll_next  = STICK_W'(STICK_CENTER);
                        stk_pitch_next = STICK_W'(STICK_CENTER);
                    end
                    idx_next   = '0;
                    state_next = S_TGT;
                end
            end
            S_TGT:
            begin
                mul_a      = {tgt_w[STATE_W-1], tgt_w};
                mul_b      = tgt_recip;
                prod_next  = mul_p[PROD_W-1:0];
                state_next = S_TGT_Q;
            end
            S_TGT_Q:
            begin
                t_next     = $signed(prod_reg[RECIP_SHIFT +: X_W]) - tgt_qofs;
                state_next = S_SMO;
            end
            S_SMO:
            begin
                mul_a      = smo_w[MUL_A_W-1:0];
                mul_b      = MUL_B_W'(RECIP_SMO);
                prod_next  = mul_p[PROD_W-1:0];
                state_next = S_SMO_Q;
            end
            S_SMO_Q:
            begin
                cmd_next[idx_reg] = $signed({{(STATE_W-X_W){1'b0}}, prod_reg[RECIP_SHIFT +: X_W]})
                                  - STATE_W'(Q_SMO);
                state_next = S_ERR;
            end
            S_ERR:
            begin
                e_next     = sat32(err_w);
                state_next = S_PI;
            end
            S_PI:
            begin
                integ_next[idx_reg] = acc_clamped[STATE_W-1:0];
                mul_a      = {e_reg[STATE_W-1], e_reg};
                mul_b      = gain_p(idx_reg);
                prod_next  = mul_p[PROD_W-1:0];
                state_next = S_II;
            end
            S_II:
            begin
                sum_next   = prod_reg;
                mul_a      = {integ_reg[idx_reg][STATE_W-1], integ_reg[idx_reg]};
                mul_b      = gain_i(idx_reg);
                prod_next  = mul_p[PROD_W-1:0];
                state_next = S_DD;
            end
            S_DD:
            begin
                sum_next   = sum_reg + prod_reg;
                mul_a      = {e_reg[STATE_W-1], e_reg}
                           - {prev_reg[idx_reg][STATE_W-1], prev_reg[idx_reg]};
                mul_b      = gain_d(idx_reg);
                prod_next  = mul_p[PROD_W-1:0];
                prev_next[idx_reg] = e_reg;
                state_next = S_U;
            end
            S_U:
            begin
                // floor of (sum + half) / 2^24 is an arithmetic shift
                u_next[idx_reg] = u_tot[GAIN_FRAC +: U_W];
                idx_next        = idx_reg + 2'd1;
                state_next      = (idx_reg == IDX_LAST) ? S_MIX : S_TGT;
            end
            S_MIX:
            begin
                if (!out_valid_reg || m_axis_tready)
                begin
                    out_data_next  = {motor_clamp(mix_tpp - mix_ym),
                                      motor_clamp(mix_tpp + mix_ym),
                                      motor_clamp(mix_tp + mix_yr),
                                      motor_clamp(mix_tp - mix_yr)};
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default:
                state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            idx_reg       <= '0;
            out_valid_reg <= 1'b0;
            yaw_ref_reg   <= '0;
            limit_reg     <= LIMIT_RESET;
            for (int i = 0; i < 4; i++)
            begin
                cmd_reg[i]   <= '0;
                integ_reg[i] <= '0;
                prev_reg[i]  <= '0;
            end
        end
        else
        begin
            state_reg     <= state_next;
            idx_reg       <= idx_next;
            out_valid_reg <= out_valid_next;
            yaw_ref_reg   <= yaw_ref_next;
            limit_reg     <= limit_next;
            cmd_reg       <= cmd_next;
            integ_reg     <= integ_next;
            prev_reg      <= prev_next;
        end
    end

    always_ff @(posedge clk)
    begin
        alt_reg       <= alt_next;
        pitch_reg     <= pitch_next;
        roll_reg      <= roll_next;
        yawm_reg      <= yawm_next;
        stk_yaw_reg   <= stk_yaw_next;
        stk_thr_reg   <= stk_thr_next;
        stk_roll_reg  <= stk_roll_next;
        stk_pitch_reg <= stk_pitch_next;
        u_reg         <= u_next;
        t_reg         <= t_next;
        e_reg         <= e_next;
        prod_reg      <= prod_next;
        sum_reg       <= sum_next;
        out_data_reg  <= out_data_next;
    end

`ifndef SYNTHESIS
    a_req_starts_loop: assert property (@(posedge clk) disable iff (!rst_n)
        in_req |=> (state_reg == S_TGT && idx_reg == IDX_ALT))
        else $error("request did not start the axis loop at altitude");

    a_last_axis_mixes: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_U && idx_reg == IDX_LAST) |=> (state_reg == S_MIX))
        else $error("last axis did not hand over to the mix");

    a_mix_delivers: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_MIX && (!m_axis_tvalid || m_axis_tready))
        |=> (m_axis_tvalid && state_reg == S_IDLE))
        else $error("mixed result not presented");

    a_smooth_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_SMO) |-> (smo_w[STATE_W+1:X_W-1] == '0))
        else $error("smoothing numerator outside reciprocal range");
`endif

endmodule
